// ===== rtl/mco_pkg.sv =====
// shared types, control word layout and constants for the matrix chain order block
package mco_pkg;

    localparam int DIM_W     = 10;
    localparam int COST_W    = 33;
    localparam int OUT_IDX_W = 3;
    localparam int STAT_W    = 2;
    localparam int UPC_W     = 5;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FEW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_DROP = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0] dim;
        logic             last;
    } cmd_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] row;
        logic [OUT_IDX_W-1:0] col;
        logic [COST_W-1:0]    cost;
        logic [OUT_IDX_W-1:0] split;
        logic [STAT_W-1:0]    status;
        logic                 final_res;
    } result_t;

    // index register operations
    typedef enum logic [3:0] {
        IX_NONE,
        IX_SETUP,
        IX_ROW_INIT,
        IX_CELL_INIT,
        IX_K_INC,
        IX_I_INC,
        IX_LEN_INC,
        IX_OUT_INIT,
        IX_OUT_NEXT
    } ix_op_t;

    // dimension store read address
    typedef enum logic [1:0] {
        DS_I1,
        DS_K,
        DS_J
    } dim_sel_t;

    // table read address mode
    typedef enum logic {
        TR_FILL,
        TR_OUT
    } tbl_rd_t;

    typedef enum logic [2:0] {
        AR_NONE,
        AR_SUM,
        AR_MUL1,
        AR_MUL2,
        AR_CMP
    } arith_t;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_CELL,
        EM_FEW
    } emit_t;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_GO,
        C_FEW,
        C_LEN_OVER,
        C_ROW_OVER,
        C_K_LAST,
        C_NOT_FINAL
    } cond_t;

    typedef struct packed {
        ix_op_t           ix;
        dim_sel_t         dsel;
        tbl_rd_t          trd;
        arith_t           ar;
        logic             twr;
        emit_t            em;
        logic             clr;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic go;
        logic few;
        logic len_over;
        logic row_over;
        logic k_last;
        logic final_cell;
    } flags_t;

endpackage

// ===== rtl/mco_seq.sv =====
// microcode sequencer: step counter, control store and conditional jumps
module mco_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  mco_pkg::flags_t flags,
    output mco_pkg::ctrl_t  ctrl,
    output logic            busy
);
    import mco_pkg::*;

    // step addresses
    localparam logic [UPC_W-1:0] S_IDLE     = UPC_W'(0);
    localparam logic [UPC_W-1:0] S_CHECK    = UPC_W'(1);
    localparam logic [UPC_W-1:0] S_SETUP    = UPC_W'(2);
    localparam logic [UPC_W-1:0] S_LEN_TOP  = UPC_W'(3);
    localparam logic [UPC_W-1:0] S_CELL_TOP = UPC_W'(4);
    localparam logic [UPC_W-1:0] S_K_RD     = UPC_W'(5);
    localparam logic [UPC_W-1:0] S_K_SUM    = UPC_W'(6);
    localparam logic [UPC_W-1:0] S_K_MUL1   = UPC_W'(7);
    localparam logic [UPC_W-1:0] S_K_MUL2   = UPC_W'(8);
    localparam logic [UPC_W-1:0] S_K_CMP    = UPC_W'(9);
    localparam logic [UPC_W-1:0] S_K_LOOP   = UPC_W'(10);
    localparam logic [UPC_W-1:0] S_WRITE    = UPC_W'(11);
    localparam logic [UPC_W-1:0] S_LEN_NEXT = UPC_W'(12);
    localparam logic [UPC_W-1:0] S_OUT_INIT = UPC_W'(13);
    localparam logic [UPC_W-1:0] S_OUT_RD   = UPC_W'(14);
    localparam logic [UPC_W-1:0] S_OUT_EMIT = UPC_W'(15);
    localparam logic [UPC_W-1:0] S_FINISH   = UPC_W'(16);
    localparam logic [UPC_W-1:0] S_FEW      = UPC_W'(17);

    localparam ctrl_t NOP_WORD = '{
        ix:     IX_NONE,
        dsel:   DS_I1,
        trd:    TR_FILL,
        ar:     AR_NONE,
        twr:    1'b0,
        em:     EM_NONE,
        clr:    1'b0,
        cond:   C_NEVER,
        target: S_IDLE
    };

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    ctrl_t            word;
    logic             take;

    // control store
    always_comb
    begin
        word = NOP_WORD;
        unique case (upc_reg)
            S_IDLE:
            begin
                word.cond   = C_NO_GO;
                word.target = S_IDLE;
            end
            S_CHECK:
            begin
                word.cond   = C_FEW;
                word.target = S_FEW;
            end
            S_SETUP:
            begin
                word.ix = IX_SETUP;
            end
            S_LEN_TOP:
            begin
                word.ix     = IX_ROW_INIT;
                word.cond   = C_LEN_OVER;
                word.target = S_OUT_INIT;
            end
            S_CELL_TOP:
            begin
                word.ix     = IX_CELL_INIT;
                word.cond   = C_ROW_OVER;
                word.target = S_LEN_NEXT;
            end
            S_K_RD:
            begin
                word.dsel = DS_I1;
                word.trd  = TR_FILL;
            end
            S_K_SUM:
            begin
                word.dsel = DS_K;
                word.ar   = AR_SUM;
            end
            S_K_MUL1:
            begin
                word.dsel = DS_J;
                word.ar   = AR_MUL1;
            end
            S_K_MUL2:
            begin
                word.ar = AR_MUL2;
            end
            S_K_CMP:
            begin
                word.ar     = AR_CMP;
                word.ix     = IX_K_INC;
                word.cond   = C_K_LAST;
                word.target = S_WRITE;
            end
            S_K_LOOP:
            begin
                word.cond   = C_ALWAYS;
                word.target = S_K_RD;
            end
            S_WRITE:
            begin
                word.twr    = 1'b1;
                word.ix     = IX_I_INC;
                word.cond   = C_ALWAYS;
                word.target = S_CELL_TOP;
            end
            S_LEN_NEXT:
            begin
                word.ix     = IX_LEN_INC;
                word.cond   = C_ALWAYS;
                word.target = S_LEN_TOP;
            end
            S_OUT_INIT:
            begin
                word.ix = IX_OUT_INIT;
            end
            S_OUT_RD:
            begin
                word.trd = TR_OUT;
            end
            S_OUT_EMIT:
            begin
                word.em     = EM_CELL;
                word.ix     = IX_OUT_NEXT;
                word.cond   = C_NOT_FINAL;
                word.target = S_OUT_RD;
            end
            S_FINISH:
            begin
                word.clr    = 1'b1;
                word.cond   = C_ALWAYS;
                word.target = S_IDLE;
            end
            S_FEW:
            begin
                word.em     = EM_FEW;
                word.cond   = C_ALWAYS;
                word.target = S_FINISH;
            end
            default:
            begin
                word.cond   = C_ALWAYS;
                word.target = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        case (word.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_GO:     take = !flags.go;
            C_FEW:       take = flags.few;
            C_LEN_OVER:  take = flags.len_over;
            C_ROW_OVER:  take = flags.row_over;
            C_K_LAST:    take = flags.k_last;
            C_NOT_FINAL: take = !flags.final_cell;
            default:     take = 1'b0;
        endcase
        upc_next = take ? word.target : upc_reg + UPC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign ctrl = word;
    assign busy = (upc_reg != S_IDLE);

endmodule

// ===== rtl/mco_dpath.sv =====
// datapath: dimension store, cost and split tables, index registers, multiplier and compare
module mco_dpath #(
    parameter int MAX_DIMS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  mco_pkg::cmd_t    cmd,
    input  mco_pkg::ctrl_t   ctrl,
    output mco_pkg::flags_t  flags,
    output mco_pkg::result_t result,
    output logic             result_valid
);
    import mco_pkg::*;

    localparam int IDX_W = $clog2(MAX_DIMS);
    localparam int CNT_W = $clog2(MAX_DIMS + 1);
    localparam int TBL_D = 2 ** (2 * IDX_W);
    localparam int P1_W  = 2 * DIM_W;
    localparam int P2_W  = 3 * DIM_W;
    localparam int SAT_W = (P2_W > COST_W) ? P2_W : COST_W;

    // storage
    logic [DIM_W-1:0]  dims_mem  [MAX_DIMS];
    logic [COST_W-1:0] cost_mem  [TBL_D];
    logic [IDX_W-1:0]  split_mem [TBL_D];

    logic [DIM_W-1:0]  dim_rd_reg;
    logic [COST_W-1:0] cost_a_reg;
    logic [COST_W-1:0] cost_b_reg;
    logic [IDX_W-1:0]  split_rd_reg;

    // control registers
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             result_valid_reg, result_valid_next;

    // payload registers
    logic [DIM_W-1:0]  a_reg, a_next;
    logic [P1_W-1:0]   p1_reg, p1_next;
    logic [COST_W-1:0] prod_reg, prod_next;
    logic [COST_W-1:0] sum_reg, sum_next;
    logic [COST_W-1:0] best_reg, best_next;
    logic [IDX_W-1:0]  best_k_reg, best_k_next;
    result_t           result_reg, result_next;

    // combinational helpers
    logic                 dim_wr;
    logic [CNT_W-1:0]     dim_idx;
    logic [IDX_W-1:0]     dim_addr;
    logic [CNT_W-1:0]     kp1;
    logic [2*IDX_W-1:0]   addr_a;
    logic [2*IDX_W-1:0]   addr_b;
    logic [2*IDX_W-1:0]   wr_addr;
    logic [COST_W-1:0]    term_a;
    logic [COST_W-1:0]    term_b;
    logic [COST_W:0]      sum_full;
    logic [COST_W-1:0]    sum_sat;
    logic [P1_W-1:0]      p1_full;
    logic [P2_W-1:0]      p2_full;
    logic [SAT_W-1:0]     p2_ext;
    logic [COST_W-1:0]    prod_sat;
    logic [COST_W:0]      cand_full;
    logic [COST_W-1:0]    cand;
    logic [CNT_W:0]       row_end;
    logic                 diag;

    assign dim_wr = accept && (count_reg < CNT_W'(MAX_DIMS));

    always_comb
    begin
        case (ctrl.dsel)
            DS_I1:   dim_idx = i_reg - CNT_W'(1);
            DS_K:    dim_idx = k_reg;
            DS_J:    dim_idx = j_reg;
            default: dim_idx = i_reg;
        endcase
    end

    assign dim_addr = dim_idx[IDX_W-1:0];
    assign kp1      = k_reg + CNT_W'(1);
    assign addr_a   = (ctrl.trd == TR_OUT) ? {i_reg[IDX_W-1:0], j_reg[IDX_W-1:0]}
                                           : {i_reg[IDX_W-1:0], k_reg[IDX_W-1:0]};
    assign addr_b   = {kp1[IDX_W-1:0], j_reg[IDX_W-1:0]};
    assign wr_addr  = {i_reg[IDX_W-1:0], j_reg[IDX_W-1:0]};

    // diagonal cells are never written, they read as zero
    assign term_a   = (k_reg == i_reg) ? '0 : cost_a_reg;
    assign term_b   = (kp1 == j_reg) ? '0 : cost_b_reg;
    assign sum_full = {1'b0, term_a} + {1'b0, term_b};
    assign sum_sat  = sum_full[COST_W] ? COST_MAX : sum_full[COST_W-1:0];

    assign p1_full  = a_reg * dim_rd_reg;
    assign p2_full  = p1_reg * dim_rd_reg;
    assign p2_ext   = SAT_W'(p2_full);
    assign prod_sat = (p2_ext > SAT_W'(COST_MAX)) ? COST_MAX : p2_ext[COST_W-1:0];

    assign cand_full = {1'b0, sum_reg} + {1'b0, prod_reg};
    assign cand      = cand_full[COST_W] ? COST_MAX : cand_full[COST_W-1:0];

    assign row_end = {1'b0, i_reg} + {1'b0, len_reg};
    assign diag    = (i_reg == j_reg);

    assign flags.go         = accept && cmd.last;
    assign flags.few        = (count_reg < CNT_W'(2));
    assign flags.len_over   = (len_reg > n_reg);
    assign flags.row_over   = (row_end > ({1'b0, n_reg} + (CNT_W + 1)'(1)));
    assign flags.k_last     = (kp1 == j_reg);
    assign flags.final_cell = (i_reg == n_reg) && (j_reg == n_reg);

    // next state
    always_comb
    begin
        count_next        = count_reg;
        ovf_next          = ovf_reg;
        n_next            = n_reg;
        len_next          = len_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        k_next            = k_reg;
        a_next            = a_reg;
        p1_next           = p1_reg;
        prod_next         = prod_reg;
        sum_next          = sum_reg;
        best_next         = best_reg;
        best_k_next       = best_k_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;

        if (ctrl.clr)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (accept)
        begin
            if (dim_wr)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        unique case (ctrl.ix)
            IX_NONE:
            begin
            end
            IX_SETUP:
            begin
                n_next   = count_reg - CNT_W'(1);
                len_next = CNT_W'(2);
            end
            IX_ROW_INIT:
            begin
                i_next = CNT_W'(1);
            end
            IX_CELL_INIT:
            begin
                j_next = i_reg + len_reg - CNT_W'(1);
                k_next = i_reg;
            end
            IX_K_INC:
            begin
                k_next = kp1;
            end
            IX_I_INC:
            begin
                i_next = i_reg + CNT_W'(1);
            end
            IX_LEN_INC:
            begin
                len_next = len_reg + CNT_W'(1);
            end
            IX_OUT_INIT:
            begin
                i_next = CNT_W'(1);
                j_next = CNT_W'(1);
            end
            IX_OUT_NEXT:
            begin
                if (j_reg == n_reg)
                begin
                    i_next = i_reg + CNT_W'(1);
                    j_next = i_reg + CNT_W'(1);
                end
                else
                begin
                    j_next = j_reg + CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase

        unique case (ctrl.ar)
            AR_NONE:
            begin
            end
            AR_SUM:
            begin
                sum_next = sum_sat;
                a_next   = dim_rd_reg;
            end
            AR_MUL1:
            begin
                p1_next = p1_full;
            end
            AR_MUL2:
            begin
                prod_next = prod_sat;
            end
            AR_CMP:
            begin
                // first candidate always loads, ties keep the smaller split
                if ((k_reg == i_reg) || (cand < best_reg))
                begin
                    best_next   = cand;
                    best_k_next = k_reg[IDX_W-1:0];
                end
            end
            default:
            begin
            end
        endcase

        unique case (ctrl.em)
            EM_NONE:
            begin
            end
            EM_CELL:
            begin
                result_valid_next     = 1'b1;
                result_next.row       = OUT_IDX_W'(i_reg);
                result_next.col       = OUT_IDX_W'(j_reg);
                result_next.cost      = diag ? '0 : cost_a_reg;
                result_next.split     = diag ? '0 : OUT_IDX_W'(split_rd_reg);
                result_next.status    = ovf_reg ? ST_DROP : ST_OK;
                result_next.final_res = flags.final_cell;
            end
            EM_FEW:
            begin
                result_valid_next     = 1'b1;
                result_next           = '0;
                result_next.status    = ST_FEW;
                result_next.final_res = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // dimension store
    always_ff @(posedge clk)
    begin
        if (dim_wr)
        begin
            dims_mem[count_reg[IDX_W-1:0]] <= cmd.dim;
        end
        dim_rd_reg <= dims_mem[dim_addr];
    end

    // cost and split tables, one write and two reads per cycle; the split table is read at the first read address only
    always_ff @(posedge clk)
    begin
        if (ctrl.twr)
        begin
            cost_mem[wr_addr]  <= best_reg;
            split_mem[wr_addr] <= best_k_reg;
        end
        cost_a_reg   <= cost_mem[addr_a];
        cost_b_reg   <= cost_mem[addr_b];
        split_rd_reg <= split_mem[addr_a];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            ovf_reg          <= 1'b0;
            n_reg            <= '0;
            len_reg          <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            k_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            ovf_reg          <= ovf_next;
            n_reg            <= n_next;
            len_reg          <= len_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            k_reg            <= k_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        p1_reg     <= p1_next;
        prod_reg   <= prod_next;
        sum_reg    <= sum_next;
        best_reg   <= best_next;
        best_k_reg <= best_k_next;
        result_reg <= result_next;
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// ===== rtl/matrix_chain_order_dp.sv =====
// top level of the matrix chain order block: sequencer plus datapath
//
//  channel   ports                   direction  handshake
//  -------   ---------------------   ---------  ------------------------------------
//  command   start, busy, cmd        in         word taken when start high, busy low
//  result    result, result_valid    out        word shown one cycle, strobe marks it
//
// a dimension word without last is stored when taken, unless the store is full, and busy stays low
// a word with last starts the microprogram; busy is high until the last result
// is out: each split candidate is read, summed, multiplied in two steps and
// compared (one dimension read port feeding a two-step product, then add and
// compare), each cell adds a row test and the table write, each chain length a
// length test and step, and each result word a table read and the emit
// fewer than two dimensions: the single result word shows after the check and
// too-few steps, and busy falls in the cycle after it shows
// reset clears the sequencer, the counters and the strobe; tables need no clearing
// the receiver cannot stall, each result word is taken in the cycle it is shown
module matrix_chain_order_dp #(
    parameter int MAX_DIMS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  mco_pkg::cmd_t    cmd,
    output mco_pkg::result_t result,
    output logic             result_valid
);
    import mco_pkg::*;

    ctrl_t  ctrl;
    flags_t flags;
    logic   accept;

    // a command word is taken only while the sequencer sits idle
    assign accept = start && !busy;

    // step counter and control store
    mco_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    // storage, index arithmetic, product and minimum search, result register
    mco_dpath #(
        .MAX_DIMS (MAX_DIMS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .cmd          (cmd),
        .ctrl         (ctrl),
        .flags        (flags),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

// ===== tb/matrix_chain_order_dp_tb.sv =====
// self-checking testbench for the matrix chain order block
`timescale 1ns / 100ps

module matrix_chain_order_dp_tb;
    import mco_pkg::*;

    localparam int MAX_DIMS = 8;
    // slowest correct run is every word closing a full chain plus the longest
    // sender gap; this limit leaves several times that margin
    localparam int CYCLE_LIMIT = 1_000_000;
    // wait longer than a full chain of eight dimensions takes
    // after the last expected word to catch anything stray
    localparam int DRAIN_CYCLES = 500;

    typedef logic [DIM_W-1:0] dim_list_t[$];

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd = '0;
    logic    busy;
    result_t result;
    logic    result_valid;

    // chance in percent that the sender idles before a word, drawn anew after each idle
    int gap_pct = 0;

    // predictor state: the dimensions held for the chain being loaded
    logic [DIM_W-1:0] chain_dims [MAX_DIMS];
    int               dims_held = 0;
    logic             dim_dropped = 1'b0;

    // cell results still owed by the block, oldest first
    result_t cell_results_q[$];

    int mismatches = 0;
    int words_taken = 0;
    int chains_closed = 0;
    int short_chains = 0;
    int overfull_chains = 0;
    int results_checked = 0;
    int cycle_count = 0;

    matrix_chain_order_dp #(
        .MAX_DIMS(MAX_DIMS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result       (result),
        .result_valid (result_valid)
    );

    always #5 clk = ~clk;

    // hard stop in case the block hangs or a result never shows up
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d result words still owed",
                     $time, cycle_count, cell_results_q.size());
            $display("matrix_chain_order_dp verification failed");
            $finish;
        end
    end

    // store one dimension word; when it closes the chain, run the
    // dynamic program and queue every cell (i <= j) in row order
    function automatic void plan_chain_costs(input cmd_t w);
        longint unsigned  cell_cost  [MAX_DIMS][MAX_DIMS];
        int               cell_split [MAX_DIMS][MAX_DIMS];
        longint unsigned  trial;
        int               n;
        int               j;
        logic [STAT_W-1:0] stat;
        result_t          r;

        if (dims_held < MAX_DIMS)
        begin
            chain_dims[dims_held] = w.dim;
            dims_held++;
        end
        else
            dim_dropped = 1'b1;   // past capacity: word is dropped, run is flagged
        if (!w.last)
            return;

        chains_closed++;
        if (dims_held < 2)
        begin
            // a lone dimension describes no matrix at all
            r           = '0;
            r.status    = ST_FEW;
            r.final_res = 1'b1;
            cell_results_q.push_back(r);
            short_chains++;
            dims_held   = 0;
            dim_dropped = 1'b0;
            return;
        end

        n    = dims_held - 1;
        stat = dim_dropped ? ST_DROP : ST_OK;
        if (dim_dropped)
            overfull_chains++;

        for (int i = 1; i <= n; i++)
        begin
            cell_cost[i][i]  = 0;
            cell_split[i][i] = 0;
        end
        // grow the subchain length; first candidate seeds the minimum and
        // only a strictly lower cost replaces it, so ties keep the smaller split
        for (int span = 2; span <= n; span++)
        begin
            for (int i = 1; i + span - 1 <= n; i++)
            begin
                j = i + span - 1;
                for (int k = i; k < j; k++)
                begin
                    trial = cell_cost[i][k] + cell_cost[k+1][j]
                          + longint'(chain_dims[i-1]) * chain_dims[k] * chain_dims[j];
                    if (trial > COST_MAX)
                        trial = COST_MAX;
                    if (k == i || trial < cell_cost[i][j])
                    begin
                        cell_cost[i][j]  = trial;
                        cell_split[i][j] = k;
                    end
                end
            end
        end

        for (int i = 1; i <= n; i++)
        begin
            for (int jj = i; jj <= n; jj++)
            begin
                r.row       = OUT_IDX_W'(i);
                r.col       = OUT_IDX_W'(jj);
                r.cost      = COST_W'(cell_cost[i][jj]);
                r.split     = OUT_IDX_W'(cell_split[i][jj]);
                r.status    = stat;
                r.final_res = (i == n && jj == n);
                cell_results_q.push_back(r);
            end
        end
        dims_held   = 0;
        dim_dropped = 1'b0;
    endfunction

    task automatic note_field(input string fname, input logic [COST_W-1:0] want,
                              input logic [COST_W-1:0] seen);
        if (seen !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, seen);
            mismatches++;
        end
    endtask

    // watch both channels at the clock edge; outputs and inputs are read
    // before any update of this edge lands, so the order of processes is moot
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                words_taken++;
                plan_chain_costs(cmd);
            end
            if (result_valid)
            begin
                if (cell_results_q.size() == 0)
                begin
                    $display("%0t: unexpected result %0d,%0d cost %0d split %0d st %0d fin %0b",
                             $time, result.row, result.col, result.cost, result.split,
                             result.status, result.final_res);
                    mismatches++;
                end
                else
                begin
                    want = cell_results_q.pop_front();
                    note_field("row",       COST_W'(want.row),       COST_W'(result.row));
                    note_field("col",       COST_W'(want.col),       COST_W'(result.col));
                    note_field("cost",      want.cost,               result.cost);
                    note_field("split",     COST_W'(want.split),     COST_W'(result.split));
                    note_field("status",    COST_W'(want.status),    COST_W'(result.status));
                    note_field("final_res", COST_W'(want.final_res),
                               COST_W'(result.final_res));
                    results_checked++;
                end
            end
        end
    end

    // present one command word and hold it until the block takes it;
    // called at a rising edge, returns at the edge that takes the word
    task automatic send_word(input cmd_t w);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= w;
        // busy only moves at the rising edge, so the mid-cycle value is
        // what the next edge will see
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    // send a dimension list, marking the final word as the end of the chain
    task automatic send_chain(input dim_list_t dims);
        cmd_t w;
        foreach (dims[d])
        begin
            w.dim  = dims[d];
            w.last = (d == dims.size() - 1);
            send_word(w);
        end
    endtask

    // a single dimension closes the chain with the too-few status
    task automatic test_lone_dimension();
        send_chain('{10'd5});
    endtask

    // one matrix at the largest dimension
    task automatic test_one_matrix();
        send_chain('{10'd1023, 10'd1023});
    endtask

    // a zero dimension zeroes every product it enters
    task automatic test_zero_dimension();
        send_chain('{10'd3, 10'd0, 10'd7});
    endtask

    // equal dimensions make every split cost the same
    task automatic test_split_ties();
        send_chain('{10'd4, 10'd4, 10'd4, 10'd4});
    endtask

    // eight maximum dimensions fill the store, the extra two are dropped;
    // also drives the largest chain cost that ten-bit dimensions can produce
    task automatic test_capacity_overflow();
        send_chain('{10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                     10'd1023, 10'd1023, 10'd1023, 10'd1, 10'd0});
    endtask

    // random chains: mostly well-formed lengths, some lone dimensions and
    // some past capacity; dimension values drawn from several styles so
    // ties, zeros, large products and every bit pattern turn up
    task automatic test_random_chains(input int quota, input int gap);
        dim_list_t dims;
        int        sent;
        int        len;
        int        pick;
        int        style;

        gap_pct = gap;
        sent    = 0;
        while (sent < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 6)
                len = 1;
            else if (pick < 16)
                len = $urandom_range(MAX_DIMS + 1, MAX_DIMS + 3);
            else
                len = $urandom_range(2, MAX_DIMS);
            style = $urandom_range(3);
            dims.delete();
            for (int d = 0; d < len; d++)
            begin
                case (style)
                    0:       dims.push_back(DIM_W'($urandom_range(1, 1023)));
                    1:       dims.push_back(DIM_W'($urandom_range(0, 7)));
                    2:       dims.push_back(DIM_W'($urandom_range(1000, 1023)));
                    default: dims.push_back(DIM_W'($urandom));
                endcase
            end
            send_chain(dims);
            sent += len;
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        gap_pct = 9;
        test_lone_dimension();
        test_one_matrix();
        test_zero_dimension();
        test_split_ties();
        test_capacity_overflow();

        // random chains: light sender gaps, heavy gaps, then back to back
        test_random_chains(117, 9);
        test_random_chains(117, 76);
        test_random_chains(117, 0);

        start <= 1'b0;
        while (cell_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d dimension words in %0d chains, %0d too short, %0d over capacity",
                 words_taken, chains_closed, short_chains, overfull_chains);
        $display("%0d result words compared field by field, %0d mismatches",
                 results_checked, mismatches);
        if (mismatches == 0)
            $display("matrix_chain_order_dp verification clean");
        else
            $display("matrix_chain_order_dp verification failed");
        $finish;
    end

endmodule
